>>> rtl/core/csem_pkg.sv
package csem_pkg;

	localparam int MAX_WAITERS_DEF    = 16;
	localparam int THREAD_ID_BITS_DEF = 8;

	localparam int REQ_W     = 2;
	localparam int TID_W     = 8;
	localparam int WAIT_W    = 16;
	localparam int INIT_W    = 15;
	localparam int COUNT_W   = 17;
	localparam int RES_W     = 2;

	// wakes reported per tick, and the counter that tracks them
	localparam int RESULT_LIMIT = 16;
	localparam int RES_N_W      = 5;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 17'sd65535;

	typedef enum logic [REQ_W-1:0] {
		REQ_WAIT   = 2'd0,
		REQ_SIGNAL = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	typedef enum logic [RES_W-1:0] {
		RES_PROCEED  = 2'd0,
		RES_BLOCKED  = 2'd1,
		RES_WOKEN    = 2'd2,
		RES_REJECTED = 2'd3
	} res_t;

	// sequencer step addresses
	typedef enum logic [3:0] {
		ST_FETCH     = 4'd0,
		ST_DECODE    = 4'd1,
		ST_WAIT      = 4'd2,
		ST_SIG_UP    = 4'd3,
		ST_SIG_UT    = 4'd4,
		ST_SIG_TMCHK = 4'd5,
		ST_SIG_TM    = 4'd6,
		ST_TK_RD     = 4'd7,
		ST_TK_UPD    = 4'd8,
		ST_TK_END    = 4'd9
	} step_t;

	typedef enum logic [3:0] {
		A_FETCH,
		A_DECODE,
		A_WAIT,
		A_SIG_UP,
		A_WAKE_UT,
		A_SIG_TM_RD,
		A_WAKE_TM,
		A_TK_RD,
		A_TK_UPD,
		A_TK_END
	} act_t;

	typedef enum logic [2:0] {
		C_ACCEPT,
		C_DISPATCH,
		C_OFREE,
		C_SIG_UT,
		C_SIG_TM,
		C_SCAN_END,
		C_TK_HOLD,
		C_END_HOLD
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		case (step)
			ST_FETCH:     cw = '{A_FETCH,     C_ACCEPT,   ST_DECODE,    ST_FETCH};
			ST_DECODE:    cw = '{A_DECODE,    C_DISPATCH, ST_FETCH,     ST_FETCH};
			ST_WAIT:      cw = '{A_WAIT,      C_OFREE,    ST_FETCH,     ST_WAIT};
			ST_SIG_UP:    cw = '{A_SIG_UP,    C_SIG_UT,   ST_SIG_UT,    ST_SIG_TMCHK};
			ST_SIG_UT:    cw = '{A_WAKE_UT,   C_OFREE,    ST_FETCH,     ST_SIG_UT};
			ST_SIG_TMCHK: cw = '{A_SIG_TM_RD, C_SIG_TM,   ST_SIG_TM,    ST_FETCH};
			ST_SIG_TM:    cw = '{A_WAKE_TM,   C_OFREE,    ST_FETCH,     ST_SIG_TM};
			ST_TK_RD:     cw = '{A_TK_RD,     C_SCAN_END, ST_TK_END,    ST_TK_UPD};
			ST_TK_UPD:    cw = '{A_TK_UPD,    C_TK_HOLD,  ST_TK_UPD,    ST_TK_RD};
			ST_TK_END:    cw = '{A_TK_END,    C_END_HOLD, ST_TK_END,    ST_FETCH};
			default:      cw = '{A_FETCH,     C_ACCEPT,   ST_DECODE,    ST_FETCH};
		endcase
		return cw;
	endfunction

endpackage

>>> rtl/core/counting_semaphore_timed_wait.sv
// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+---------------------------------------------
// in      | in  | in_valid / in_stall | req_type, thread_id, wait_time
// out     | out | out_valid/out_stall | event_res, woken_thread, return_value, last
// cfg     | in  | cfg_we              | cfg_wdata (initial_count)
//
// An item is taken only in the fetch step. A tick spends a read-then-update pair
//   of sequencer steps on each timed-queue entry (one memory read port).
// Reset: count 0, both queues empty; queue memories are not cleared.
// Out stalls hold the sequencer at any step that has a beat to deliver.
module counting_semaphore_timed_wait #(
	parameter int MAX_WAITERS    = csem_pkg::MAX_WAITERS_DEF,
	parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [csem_pkg::REQ_W-1:0]    req_type,
	input  logic [csem_pkg::TID_W-1:0]    thread_id,
	input  logic [csem_pkg::WAIT_W-1:0]   wait_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [csem_pkg::RES_W-1:0]    event_res,
	output logic [csem_pkg::TID_W-1:0]    woken_thread,
	output logic                          return_value,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [csem_pkg::INIT_W-1:0]   cfg_wdata
);

	localparam int TB = THREAD_ID_BITS;
	localparam int WW = csem_pkg::WAIT_W;
	localparam int CW = csem_pkg::COUNT_W;
	localparam int NW = csem_pkg::RES_N_W;
	localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int LW = $clog2(MAX_WAITERS + 1);
	localparam logic [LW-1:0] LEN_ONE = LW'(1);
	localparam logic [LW-1:0] MAXL    = LW'(MAX_WAITERS);
	localparam logic [LW:0]   MAXS    = (LW+1)'(MAX_WAITERS);
	localparam logic [NW-1:0] NLIMIT  = NW'(csem_pkg::RESULT_LIMIT);

	// sequencer
	csem_pkg::step_t upc_q, upc_d;
	csem_pkg::ctrl_t cw;
	logic            ctrue;

	// latched request
	logic [csem_pkg::REQ_W-1:0] req_q;
	logic [TB-1:0]              tid_q;
	logic [WW-1:0]              wt_q;

	// semaphore state
	logic signed [CW-1:0] count_q;
	logic [AW-1:0]        ut_head_q, tm_head_q;
	logic [LW-1:0]        ut_len_q, tm_len_q;

	// tick scan
	logic [LW-1:0] i_q, w_q;
	logic [NW-1:0] n_q;
	logic          pend_valid_q;
	logic [TB-1:0] pend_tid_q;

	// queue memories
	logic [TB-1:0]    ut_mem [MAX_WAITERS];
	logic [TB+WW-1:0] tm_mem [MAX_WAITERS];
	logic [TB-1:0]    ut_rd_q;
	logic [TB+WW-1:0] tm_rd_q;

	// output register
	logic                 out_valid_q;
	csem_pkg::res_t       out_res_q;
	logic [csem_pkg::TID_W-1:0] out_tid_q;
	logic                 out_rv_q;
	logic                 out_last_q;

	// combinational
	logic                 accept, ofree;
	logic                 count_pos, wt_zero, ut_full, tm_full;
	logic signed [CW-1:0] c_up, c_dn;
	logic [AW-1:0]        ut_tail, tm_tail, tk_rd_addr, tk_wr_addr, ut_head_inc, tm_head_inc;
	logic [TB-1:0]        tid_in, rd_id;
	logic [WW-1:0]        rd_rem, tk_dec;
	logic                 tk_keep, tk_wake, tk_hold, end_hold;
	logic                 push;
	csem_pkg::res_t       push_res;
	logic [TB-1:0]        push_tid;
	logic [csem_pkg::TID_W-1:0] push_tid8;
	logic                 push_rv, push_last;
	logic                 ut_we, ut_re, tm_we, tm_re;
	logic [AW-1:0]        tm_wr_addr, tm_rd_addr;
	logic [TB+WW-1:0]     tm_wr_data;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [LW-1:0] off);
		logic [LW:0] sum;
		sum = (LW+1)'(base) + (LW+1)'(off);
		if (sum >= MAXS) sum = sum - MAXS;
		return sum[AW-1:0];
	endfunction

	generate
		if (TB > csem_pkg::TID_W) begin : g_tid_wide
			assign tid_in    = {{(TB-csem_pkg::TID_W){1'b0}}, thread_id};
			assign push_tid8 = push_tid[csem_pkg::TID_W-1:0];
		end else if (TB == csem_pkg::TID_W) begin : g_tid_same
			assign tid_in    = thread_id;
			assign push_tid8 = push_tid;
		end else begin : g_tid_narrow
			assign tid_in    = thread_id[TB-1:0];
			assign push_tid8 = {{(csem_pkg::TID_W-TB){1'b0}}, push_tid};
		end
	endgenerate

	assign cw       = csem_pkg::ucode(upc_q);
	assign in_stall = (upc_q != csem_pkg::ST_FETCH);
	assign accept   = in_valid && !in_stall;
	assign ofree    = !out_valid_q || !out_stall;

	assign count_pos = (count_q > 17'sd0);
	assign c_up      = (count_q == csem_pkg::COUNT_MAX) ? count_q : count_q + 17'sd1;
	assign c_dn      = count_q - 17'sd1;
	assign wt_zero   = (wt_q == '0);
	assign ut_full   = (ut_len_q == MAXL);
	assign tm_full   = (tm_len_q == MAXL);

	assign ut_tail     = wrap_add(ut_head_q, ut_len_q);
	assign tm_tail     = wrap_add(tm_head_q, tm_len_q);
	assign tk_rd_addr  = wrap_add(tm_head_q, i_q);
	assign tk_wr_addr  = wrap_add(tm_head_q, w_q);
	assign ut_head_inc = wrap_add(ut_head_q, LEN_ONE);
	assign tm_head_inc = wrap_add(tm_head_q, LEN_ONE);

	// tick update of one timed entry; a waiter past the wake limit stays at 1
	assign rd_id    = tm_rd_q[TB+WW-1:WW];
	assign rd_rem   = tm_rd_q[WW-1:0];
	assign tk_dec   = rd_rem - WW'(1);
	assign tk_keep  = (rd_rem == WW'(1)) && (n_q >= NLIMIT);
	assign tk_wake  = !tk_keep && (tk_dec == '0);
	assign tk_hold  = tk_wake && pend_valid_q && !ofree;
	assign end_hold = pend_valid_q && !ofree;

	// next step
	always_comb begin
		case (cw.cond)
			csem_pkg::C_ACCEPT:   ctrue = accept;
			csem_pkg::C_OFREE:    ctrue = ofree;
			csem_pkg::C_SIG_UT:   ctrue = (c_up <= 17'sd0) && (ut_len_q != '0);
			csem_pkg::C_SIG_TM:   ctrue = (count_q <= 17'sd0) && (tm_len_q != '0);
			csem_pkg::C_SCAN_END: ctrue = (i_q == tm_len_q);
			csem_pkg::C_TK_HOLD:  ctrue = tk_hold;
			csem_pkg::C_END_HOLD: ctrue = end_hold;
			default:              ctrue = 1'b0;
		endcase
		upc_d = ctrue ? cw.tgt_t : cw.tgt_f;
		if (cw.cond == csem_pkg::C_DISPATCH) begin
			case (req_q)
				csem_pkg::REQ_WAIT:   upc_d = csem_pkg::ST_WAIT;
				csem_pkg::REQ_SIGNAL: upc_d = csem_pkg::ST_SIG_UP;
				csem_pkg::REQ_TICK:   upc_d = csem_pkg::ST_TK_RD;
				default:              upc_d = csem_pkg::ST_FETCH;
			endcase
		end
	end

	// control strobes and beat contents
	always_comb begin
		push       = 1'b0;
		push_res   = csem_pkg::RES_WOKEN;
		push_tid   = tid_q;
		push_rv    = 1'b0;
		push_last  = 1'b1;
		ut_we      = 1'b0;
		ut_re      = 1'b0;
		tm_we      = 1'b0;
		tm_re      = 1'b0;
		tm_wr_addr = tm_tail;
		tm_wr_data = {tid_q, wt_q};
		tm_rd_addr = tm_head_q;
		case (cw.act)
			csem_pkg::A_WAIT: begin
				push = 1'b1;
				if (count_pos) begin
					push_res = csem_pkg::RES_PROCEED;
					push_rv  = 1'b1;
				end else if (wt_zero) begin
					push_res = ut_full ? csem_pkg::RES_REJECTED : csem_pkg::RES_BLOCKED;
					ut_we    = ofree && !ut_full;
				end else begin
					push_res = tm_full ? csem_pkg::RES_REJECTED : csem_pkg::RES_BLOCKED;
					tm_we    = ofree && !tm_full;
				end
			end
			csem_pkg::A_SIG_UP: ut_re = 1'b1;
			csem_pkg::A_WAKE_UT: begin
				push     = 1'b1;
				push_tid = ut_rd_q;
				push_rv  = 1'b1;
			end
			csem_pkg::A_SIG_TM_RD: tm_re = 1'b1;
			csem_pkg::A_WAKE_TM: begin
				push     = 1'b1;
				push_tid = rd_id;
				push_rv  = 1'b1;
			end
			csem_pkg::A_TK_RD: begin
				tm_re      = 1'b1;
				tm_rd_addr = tk_rd_addr;
			end
			csem_pkg::A_TK_UPD: begin
				// previous wake goes out once we know it is not the final beat
				push       = tk_wake && pend_valid_q;
				push_tid   = pend_tid_q;
				push_last  = 1'b0;
				tm_we      = !tk_wake;
				tm_wr_addr = tk_wr_addr;
				tm_wr_data = {rd_id, tk_keep ? rd_rem : tk_dec};
			end
			csem_pkg::A_TK_END: begin
				push     = pend_valid_q;
				push_tid = pend_tid_q;
			end
			default: ;
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q        <= csem_pkg::ST_FETCH;
			count_q      <= '0;
			ut_head_q    <= '0;
			ut_len_q     <= '0;
			tm_head_q    <= '0;
			tm_len_q     <= '0;
			i_q          <= '0;
			w_q          <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			case (cw.act)
				csem_pkg::A_DECODE: begin
					i_q          <= '0;
					w_q          <= '0;
					n_q          <= '0;
					pend_valid_q <= 1'b0;
				end
				csem_pkg::A_WAIT: begin
					if (ofree) begin
						if (count_pos) begin
							count_q <= c_dn;
						end else if (wt_zero) begin
							if (!ut_full) begin
								count_q  <= c_dn;
								ut_len_q <= ut_len_q + LEN_ONE;
							end
						end else if (!tm_full) begin
							count_q  <= c_dn;
							tm_len_q <= tm_len_q + LEN_ONE;
						end
					end
				end
				csem_pkg::A_SIG_UP: count_q <= c_up;
				csem_pkg::A_WAKE_UT: begin
					if (ofree) begin
						ut_head_q <= ut_head_inc;
						ut_len_q  <= ut_len_q - LEN_ONE;
					end
				end
				csem_pkg::A_WAKE_TM: begin
					if (ofree) begin
						tm_head_q <= tm_head_inc;
						tm_len_q  <= tm_len_q - LEN_ONE;
					end
				end
				csem_pkg::A_TK_UPD: begin
					if (!tk_hold) begin
						i_q <= i_q + LEN_ONE;
						if (tk_wake) begin
							n_q          <= n_q + NW'(1);
							count_q      <= c_up;
							pend_valid_q <= 1'b1;
						end else begin
							w_q <= w_q + LEN_ONE;
						end
					end
				end
				csem_pkg::A_TK_END: begin
					tm_len_q <= w_q;
					if (ofree) pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
			// new creation: reload count, drop all waiters
			if (cfg_we) begin
				count_q   <= $signed({2'b00, cfg_wdata});
				ut_head_q <= '0;
				ut_len_q  <= '0;
				tm_head_q <= '0;
				tm_len_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			tid_q <= tid_in;
			wt_q  <= wait_time;
		end
		if (cw.act == csem_pkg::A_TK_UPD && tk_wake && !tk_hold) pend_tid_q <= rd_id;
	end

	always_ff @(posedge clk) begin
		if (ut_we) ut_mem[ut_tail] <= tid_q;
		if (ut_re) ut_rd_q <= ut_mem[ut_head_q];
	end

	always_ff @(posedge clk) begin
		if (tm_we) tm_mem[tm_wr_addr] <= tm_wr_data;
		if (tm_re) tm_rd_q <= tm_mem[tm_rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push && ofree) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && ofree) begin
			out_res_q  <= push_res;
			out_tid_q  <= push_tid8;
			out_rv_q   <= push_rv;
			out_last_q <= push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_res_q;
	assign woken_thread = out_tid_q;
	assign return_value = out_rv_q;
	assign last         = out_last_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ut_len_q <= MAXL) && (tm_len_q <= MAXL))
		else $error("queue length beyond depth");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken before decode");

	a_pend_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (upc_q == csem_pkg::ST_TK_RD || upc_q == csem_pkg::ST_TK_UPD
			|| upc_q == csem_pkg::ST_TK_END))
		else $error("pending wake outside tick scan");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(w_q <= i_q) && (n_q <= NLIMIT))
		else $error("tick compaction pointers out of order");

	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == csem_pkg::ST_TK_END && !cfg_we) |=> (tm_len_q == $past(w_q)))
		else $error("timed length not taken from scan");
`endif

endmodule
